### rtl/core/lmt_pkg.sv
// Package of the local midrange threshold block.
// Holds the sizes, register indexes, state type and cell link type.
// Used by lmt_cell and local_midrange_threshold.
package lmt_pkg;

	localparam int MAX_WINDOW = 7;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = (MAX_WINDOW - 1) / 2;

	localparam int PIX_W = 8;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int WID_W = 11;
	localparam int HGT_W = 13;
	localparam int WIN_W = 3;
	localparam int CFG_W = 13;

	localparam int TAG_W  = $clog2(MAX_WINDOW);
	localparam int ADDR_W = $clog2(MAX_WINDOW * MAX_WIDTH);
	localparam int RAD_W  = $clog2(MAX_RADIUS + 1);

	// Cycles from the last window read until every cell has seen its pixel.
	localparam int DRAIN_CYC = MAX_WINDOW + 2;
	localparam int DRN_W     = $clog2(DRAIN_CYC + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSTART,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [PIX_W-1:0] data;
	} link_t;

endpackage

### rtl/core/lmt_cell.sv
// One cell of the window reduction chain.
// Keeps the maximum and minimum of one window row and passes pixels on.
// Depends on lmt_pkg.
module lmt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic [lmt_pkg::TAG_W-1:0] idx,
	input  lmt_pkg::link_t            link_in,
	output lmt_pkg::link_t            link_out,
	output logic [lmt_pkg::PIX_W-1:0] acc_max,
	output logic [lmt_pkg::PIX_W-1:0] acc_min
);

	lmt_pkg::link_t            link_q;
	logic [lmt_pkg::PIX_W-1:0] max_q;
	logic [lmt_pkg::PIX_W-1:0] min_q;
	logic                      mine;

	assign mine = link_in.valid && (link_in.tag == idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
			max_q  <= '0;
			min_q  <= '1;
		end else begin
			link_q <= link_in;
			if (clr) begin
				max_q <= '0;
				min_q <= '1;
			end else if (mine) begin
				if (link_in.data > max_q) max_q <= link_in.data;
				if (link_in.data < min_q) min_q <= link_in.data;
			end
		end
	end

	assign link_out = link_q;
	assign acc_max  = max_q;
	assign acc_min  = min_q;

endmodule

### rtl/core/local_midrange_threshold.sv
// Top level of the local midrange threshold block.
// Holds the line store, the frame counters, the window scan sequencer and the cell chain.
// Depends on lmt_pkg and lmt_cell.

// Pixels enter in raster order and are written to a line store of seven rows. A pixel that
// completes windows then produces its results one after another. Each result has a setup
// state, a scan that reads the pixels of its clipped window one at a time (at most 49, read
// through the single read port of the line store), a drain of the cell chain and a load of the
// output register, which waits while the previous result has not left. A new pixel is taken
// once all results of the previous one sit in, or have left, the output register. The line
// store needs no clearing after reset.
module local_midrange_threshold (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // pixel[7:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // col[9:0], row[21:10], foreground[22]
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [lmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lmt_pkg::CFG_W-1:0]     cfg_data
);

	localparam int PW = lmt_pkg::PIX_W;
	localparam int CW = lmt_pkg::COL_W;
	localparam int RW = lmt_pkg::ROW_W;
	localparam int TW = lmt_pkg::TAG_W;
	localparam int AW = lmt_pkg::ADDR_W;

	lmt_pkg::state_t state_q, state_nx;

	logic [lmt_pkg::WID_W-1:0] width_q;
	logic [lmt_pkg::HGT_W-1:0] height_q;
	logic [lmt_pkg::WIN_W-1:0] winsz_q;
	logic [lmt_pkg::WID_W-1:0] w_eff;
	logic [lmt_pkg::HGT_W-1:0] h_eff;
	logic [lmt_pkg::RAD_W-1:0] rad;
	logic [RW-1:0]             rad_r;
	logic [CW-1:0]             rad_c;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [TW-1:0] slot_q;
	logic [CW-1:0] acc_c;
	logic [RW-1:0] acc_r;
	logic [TW-1:0] acc_slot;
	logic          in_xfer;
	logic          col_more, row_more;

	logic          span_ok;
	logic [RW-1:0] ylo, yhi;
	logic [CW-1:0] xlo, xhi;

	logic [RW-1:0] yhi_q, rcur_q, cy_q;
	logic [CW-1:0] xlo_q, xhi_q, cx_q;
	logic [TW-1:0] rslot_q;

	logic [RW-1:0] wy0, wy1, wy0_q, wy1_q, sy_q;
	logic [CW-1:0] wx0, wx1, wx0_q, wx1_q, sx_q;
	logic          scan_end;
	logic [TW-1:0] row_back;
	logic [TW:0]   slot_wide;
	logic [TW-1:0] rd_slot;
	logic [AW-1:0] rd_addr, wr_addr;

	logic [lmt_pkg::DRN_W-1:0] drn_q;
	logic                      drn_end;

	logic          clr, rd_en, load_out, last_res;

	logic [PW-1:0] mem [lmt_pkg::MAX_WINDOW * lmt_pkg::MAX_WIDTH];
	logic [PW-1:0] rd_s1;
	logic          rd_vld_s1, rd_ctr_s1;
	logic [TW-1:0] rd_tag_s1;
	logic [PW-1:0] centre_q;

	lmt_pkg::link_t links [lmt_pkg::MAX_WINDOW+1];
	logic [PW-1:0]  cmax [lmt_pkg::MAX_WINDOW];
	logic [PW-1:0]  cmin [lmt_pkg::MAX_WINDOW];
	logic [PW-1:0]  mx, mn;
	logic [PW:0]    thr;
	logic           fg;
	logic           any_link;

	logic          m_valid_q;
	logic [23:0]   m_data_q;
	logic          m_last_q;

	// Out-of-range register values act as the nearest legal value.
	always_comb begin
		if (width_q == '0) w_eff = lmt_pkg::WID_W'(1);
		else if (width_q > lmt_pkg::WID_W'(lmt_pkg::MAX_WIDTH))
			w_eff = lmt_pkg::WID_W'(lmt_pkg::MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = lmt_pkg::HGT_W'(1);
		else if (height_q > lmt_pkg::HGT_W'(lmt_pkg::MAX_HEIGHT))
			h_eff = lmt_pkg::HGT_W'(lmt_pkg::MAX_HEIGHT);
		else h_eff = height_q;
		if (winsz_q == '0) rad = '0;
		else rad = lmt_pkg::RAD_W'((winsz_q - lmt_pkg::WIN_W'(1)) >> 1);
	end

	assign rad_r = RW'(rad);
	assign rad_c = CW'(rad);

	// Position of the accepted pixel; a stale position after a shrink starts a new frame.
	always_comb begin
		if ({1'b0, row_q} >= h_eff || {1'b0, col_q} >= w_eff) begin
			acc_r    = '0;
			acc_c    = '0;
			acc_slot = '0;
		end else begin
			acc_r    = row_q;
			acc_c    = col_q;
			acc_slot = slot_q;
		end
		col_more = ({1'b0, acc_c} + lmt_pkg::WID_W'(1)) < w_eff;
		row_more = ({1'b0, acc_r} + lmt_pkg::HGT_W'(1)) < h_eff;
	end

	// Span of centres whose clipped window this pixel completes.
	always_comb begin
		span_ok = 1'b1;
		if (row_more) begin
			if (acc_r < rad_r) span_ok = 1'b0;
			ylo = acc_r - rad_r;
			yhi = acc_r - rad_r;
		end else begin
			ylo = (acc_r >= rad_r) ? acc_r - rad_r : '0;
			yhi = acc_r;
		end
		if (col_more) begin
			if (acc_c < rad_c) span_ok = 1'b0;
			xlo = acc_c - rad_c;
			xhi = acc_c - rad_c;
		end else begin
			xlo = (acc_c >= rad_c) ? acc_c - rad_c : '0;
			xhi = acc_c;
		end
	end

	// Clipped window of the current centre.
	always_comb begin
		wy0 = (cy_q >= rad_r) ? cy_q - rad_r : '0;
		wy1 = (({1'b0, cy_q} + lmt_pkg::HGT_W'(rad)) < h_eff) ? cy_q + rad_r
			: RW'(h_eff - lmt_pkg::HGT_W'(1));
		wx0 = (cx_q >= rad_c) ? cx_q - rad_c : '0;
		wx1 = (({1'b0, cx_q} + lmt_pkg::WID_W'(rad)) < w_eff) ? cx_q + rad_c
			: CW'(w_eff - lmt_pkg::WID_W'(1));
	end

	// Rows of a window lie at most six rows above the newest one, so the slot is
	// the newest slot stepped back by that distance.
	always_comb begin
		row_back = TW'(rcur_q - sy_q);
		if (rslot_q >= row_back) slot_wide = {1'b0, rslot_q} - {1'b0, row_back};
		else slot_wide = {1'b0, rslot_q} + (TW+1)'(lmt_pkg::MAX_WINDOW) - {1'b0, row_back};
		rd_slot  = TW'(slot_wide);
		rd_addr  = AW'(rd_slot) * AW'(lmt_pkg::MAX_WIDTH) + AW'(sx_q);
		wr_addr  = AW'(acc_slot) * AW'(lmt_pkg::MAX_WIDTH) + AW'(acc_c);
		scan_end = (sx_q >= wx1_q) && (sy_q >= wy1_q);
		drn_end  = drn_q == lmt_pkg::DRN_W'(lmt_pkg::DRAIN_CYC - 1);
		last_res = (cy_q == yhi_q) && (cx_q == xhi_q);
	end

	assign in_xfer = s_tvalid && s_tready;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lmt_pkg::ST_IDLE:   if (in_xfer && span_ok) state_nx = lmt_pkg::ST_CSTART;
			lmt_pkg::ST_CSTART: state_nx = lmt_pkg::ST_SCAN;
			lmt_pkg::ST_SCAN:   if (scan_end) state_nx = lmt_pkg::ST_DRAIN;
			lmt_pkg::ST_DRAIN:  if (drn_end) state_nx = lmt_pkg::ST_EMIT;
			lmt_pkg::ST_EMIT: begin
				if (load_out) state_nx = last_res ? lmt_pkg::ST_IDLE : lmt_pkg::ST_CSTART;
			end
			default:            state_nx = lmt_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready = 1'b0;
		clr      = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			lmt_pkg::ST_IDLE:   s_tready = 1'b1;
			lmt_pkg::ST_CSTART: clr = 1'b1;
			lmt_pkg::ST_SCAN:   rd_en = 1'b1;
			lmt_pkg::ST_DRAIN:  ;
			lmt_pkg::ST_EMIT:   load_out = !m_valid_q || m_tready;
			default:            ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lmt_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	// Registers and frame counters; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lmt_pkg::WID_W'(640);
			height_q <= lmt_pkg::HGT_W'(480);
			winsz_q  <= lmt_pkg::WIN_W'(3);
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_we && (cfg_index == lmt_pkg::REG_WIDTH || cfg_index == lmt_pkg::REG_HEIGHT
				|| cfg_index == lmt_pkg::REG_WINDOW)) begin
			if (cfg_index == lmt_pkg::REG_WIDTH) width_q <= cfg_data[lmt_pkg::WID_W-1:0];
			if (cfg_index == lmt_pkg::REG_HEIGHT) height_q <= cfg_data;
			if (cfg_index == lmt_pkg::REG_WINDOW) winsz_q <= cfg_data[lmt_pkg::WIN_W-1:0];
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (in_xfer) begin
			if (col_more) begin
				col_q  <= acc_c + CW'(1);
				row_q  <= acc_r;
				slot_q <= acc_slot;
			end else begin
				col_q <= '0;
				if (row_more) begin
					row_q  <= acc_r + RW'(1);
					slot_q <= (acc_slot == TW'(lmt_pkg::MAX_WINDOW - 1)) ? '0
						: acc_slot + TW'(1);
				end else begin
					row_q  <= '0;
					slot_q <= '0;
				end
			end
		end
	end

	// Centre and window scan registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			yhi_q   <= yhi;
			xlo_q   <= xlo;
			xhi_q   <= xhi;
			cy_q    <= ylo;
			cx_q    <= xlo;
			rcur_q  <= acc_r;
			rslot_q <= acc_slot;
		end
		if (state_q == lmt_pkg::ST_CSTART) begin
			wy0_q <= wy0;
			wy1_q <= wy1;
			wx0_q <= wx0;
			wx1_q <= wx1;
			sy_q  <= wy0;
			sx_q  <= wx0;
		end else if (rd_en && !scan_end) begin
			if (sx_q < wx1_q) sx_q <= sx_q + CW'(1);
			else begin
				sx_q <= wx0_q;
				sy_q <= sy_q + RW'(1);
			end
		end
		if (load_out && !last_res) begin
			if (cx_q < xhi_q) cx_q <= cx_q + CW'(1);
			else begin
				cx_q <= xlo_q;
				cy_q <= cy_q + RW'(1);
			end
		end
		if (rd_vld_s1 && rd_ctr_s1) centre_q <= rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) drn_q <= '0;
		else if (state_q == lmt_pkg::ST_DRAIN) drn_q <= drn_end ? '0 : drn_q + lmt_pkg::DRN_W'(1);
		else drn_q <= '0;
	end

	// Line store.
	always_ff @(posedge clk) begin
		if (in_xfer) mem[wr_addr] <= s_tdata;
		if (rd_en) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_ctr_s1 <= 1'b0;
			rd_tag_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_ctr_s1 <= rd_en && (sy_q == cy_q) && (sx_q == cx_q);
			rd_tag_s1 <= TW'(sy_q - wy0_q);
		end
	end

	assign links[0] = '{valid: rd_vld_s1, tag: rd_tag_s1, data: rd_s1};

	for (genvar k = 0; k < lmt_pkg::MAX_WINDOW; k++) begin : g_cell
		lmt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (clr),
			.idx      (TW'(k)),
			.link_in  (links[k]),
			.link_out (links[k+1]),
			.acc_max  (cmax[k]),
			.acc_min  (cmin[k])
		);
	end

	// Combine the per-row extremes and compare the centre with the midrange.
	always_comb begin
		mx       = '0;
		mn       = '1;
		any_link = 1'b0;
		for (int k = 0; k < lmt_pkg::MAX_WINDOW; k++) begin
			if (cmax[k] > mx) mx = cmax[k];
			if (cmin[k] < mn) mn = cmin[k];
		end
		for (int k = 0; k <= lmt_pkg::MAX_WINDOW; k++) any_link = any_link | links[k].valid;
		thr = ({1'b0, mx} + {1'b0, mn}) >> 1;
		fg  = {1'b0, centre_q} > thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (load_out) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {1'b0, fg, cy_q, cx_q};
			m_last_q <= last_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// The drain time must cover the whole cell chain.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmt_pkg::ST_EMIT |-> !any_link)
		else $error("cell chain still busy when the result is formed");

	// Scanned rows never lie below the newest stored row.
	a_scan_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmt_pkg::ST_SCAN |-> (sy_q <= rcur_q) && (rcur_q - sy_q < RW'(lmt_pkg::MAX_WINDOW)))
		else $error("window row outside the line store");

	// A result appears only from the emit state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && state_q != lmt_pkg::ST_EMIT) |=> !m_tvalid)
		else $error("result appeared outside the emit state");

	// No new pixel is taken while a window is scanned or drained.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmt_pkg::ST_SCAN || state_q == lmt_pkg::ST_DRAIN) |-> !s_tready)
		else $error("pixel accepted during a window scan");

endmodule

### tb/tb_top.sv
// Self-checking testbench for local_midrange_threshold: streams gray frames, predicts every
// threshold decision with its own line store and counters, and checks the output stream.
// Depends on lmt_pkg and the RTL of local_midrange_threshold.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lmt_pkg::*;

	// An index past the register list; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		bit [COL_W-1:0] col;
		bit [ROW_W-1:0] row;
		bit             fg;
		bit             last;
	} decision_t;

	class threshold_scoreboard;
		bit [WID_W-1:0] width_reg  = 640;
		bit [HGT_W-1:0] height_reg = 480;
		bit [WIN_W-1:0] window_reg = 3;
		int unsigned    next_col, next_row;
		bit [7:0]       rows[MAX_WINDOW * MAX_WIDTH];
		decision_t      pending_q[$];
		int             mismatches, decisions, pixels;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_WIDTH: width_reg = val[WID_W-1:0];
				REG_HEIGHT: height_reg = val[HGT_W-1:0];
				REG_WINDOW: window_reg = val[WIN_W-1:0];
				default: return;
			endcase
			next_col = 0;
			next_row = 0;
		endfunction

		function bit [7:0] pix(int unsigned y, int unsigned x);
			return rows[(y % MAX_WINDOW) * MAX_WIDTH + (x % MAX_WIDTH)];
		endfunction

		// Centres along one axis whose clipped window is closed by position p.
		function bit centre_span(int unsigned p, int unsigned n, int unsigned r,
				output int unsigned lo, output int unsigned hi);
			lo = 0;
			hi = 0;
			if (p + 1 < n) begin
				if (p < r)
					return 0;
				lo = p - r;
				hi = p - r;
				return 1;
			end
			lo = (p >= r) ? p - r : 0;
			hi = p;
			return 1;
		endfunction

		function bit is_white(int unsigned y, int unsigned x, int unsigned w, int unsigned h,
				int unsigned r);
			int unsigned y0, y1, x0, x1, mx, mn, v;
			y0 = (y >= r) ? y - r : 0;
			y1 = (y + r < h) ? y + r : h - 1;
			x0 = (x >= r) ? x - r : 0;
			x1 = (x + r < w) ? x + r : w - 1;
			mx = 0;
			mn = 255;
			for (int unsigned yy = y0; yy <= y1; yy++)
				for (int unsigned xx = x0; xx <= x1; xx++) begin
					v = pix(yy, xx);
					if (v > mx) mx = v;
					if (v < mn) mn = v;
				end
			return pix(y, x) > ((mx + mn) >> 1);
		endfunction

		function void note_pixel(bit [7:0] p);
			int unsigned w, h, r, ry, cx, ylo, yhi, xlo, xhi, n;
			decision_t d;
			w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
			r = (window_reg >= 1) ? (window_reg - 1) / 2 : 0;
			if (r > MAX_RADIUS) r = MAX_RADIUS;
			ry = next_row;
			cx = next_col;
			if (ry >= h || cx >= w) begin
				ry = 0;
				cx = 0;
			end
			rows[(ry % MAX_WINDOW) * MAX_WIDTH + (cx % MAX_WIDTH)] = p;
			pixels++;
			n = 0;
			if (centre_span(ry, h, r, ylo, yhi) && centre_span(cx, w, r, xlo, xhi)) begin
				for (int unsigned y = ylo; y <= yhi; y++)
					for (int unsigned x = xlo; x <= xhi; x++) begin
						d.col = COL_W'(x);
						d.row = ROW_W'(y);
						d.fg = is_white(y, x, w, h, r);
						d.last = 0;
						pending_q.push_back(d);
						n++;
					end
				if (n > 0) pending_q[pending_q.size() - 1].last = 1;
			end
			if (cx + 1 < w) begin
				cx++;
			end else begin
				cx = 0;
				ry = (ry + 1 < h) ? ry + 1 : 0;
			end
			next_col = cx % MAX_WIDTH;
			next_row = ry % MAX_HEIGHT;
		endfunction

		function void check(bit [COL_W-1:0] col, bit [ROW_W-1:0] row, bit fg, bit last);
			decision_t d;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing expected: col %0d row %0d fg %0d last %0d",
						col, row, fg, last);
				return;
			end
			d = pending_q.pop_front();
			decisions++;
			if (d.col !== col || d.row !== row || d.fg !== fg || d.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: expected col %0d row %0d fg %0d last %0d, got %0d %0d %0d %0d",
						d.col, d.row, d.fg, d.last, col, row, fg, last);
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [23:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;

	threshold_scoreboard sb = new();
	int src_idle = 0;
	int sink_stall = 0;
	int frames = 0;

	local_midrange_threshold dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata[9:0], m_tdata[21:10], m_tdata[22], m_tlast);
	end

	// Called at a rising edge; returns at the edge where the transfer took place.
	task automatic send_pixel(bit [7:0] p);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(p);
	endtask

	// Registers are written only after every expected result has left the block.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_frame(int w, int h, int win);
		write_reg(REG_WIDTH, CFG_W'(w));
		write_reg(REG_HEIGHT, CFG_W'(h));
		write_reg(REG_WINDOW, CFG_W'(win));
		frames++;
	endtask

	function automatic bit [7:0] pick_pixel(int mode, bit [7:0] base);
		case (mode)
			0: return 8'($urandom_range(255));
			1: return $urandom_range(1) ? 8'hFF : 8'h00;
			2: return 8'(base + $urandom_range(3));
			default: return base;
		endcase
	endfunction

	initial begin
		#20ms;
		$display("Run timed out.");
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int w, h, win, cnt, mode, sent;
		bit [7:0] base;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: corners and edges of a 3x3 frame with one-hot pixel values and a zero.
		src_idle = 9;
		sink_stall = 49;
		set_frame(3, 3, 3);
		foreach (base[i]) send_pixel(8'h1 << i);
		send_pixel(8'h00);
		// Zero width, height and window act as one: every pixel is its own frame.
		set_frame(0, 0, 0);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'h80);
		// An even window acts one smaller; an unlisted index must not restart the frame.
		set_frame(4, 2, 2);
		repeat (3) send_pixel(8'($urandom_range(255)));
		write_reg(REG_UNUSED, 13'h1FFF);
		repeat (5) send_pixel(8'($urandom_range(255)));
		// Oversized registers clip to the largest frame.
		set_frame(2047, 8191, 7);
		repeat (6) send_pixel(8'($urandom_range(255)));

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 9 : (phase == 1) ? 49 : 0;
			sink_stall = (phase == 0) ? 49 : (phase == 1) ? 9 : 0;
			sent = 0;
			while (sent < 90) begin
				w = $urandom_range(9) == 0 ? $urandom_range(40, 16) : $urandom_range(12, 1);
				h = $urandom_range(8, 1);
				win = $urandom_range(7);
				set_frame(w, h, win);
				cnt = w * h;
				case ($urandom_range(9))
					0: cnt = $urandom_range(cnt, 1);
					1: cnt = cnt + cnt / 2 + 1;
					default: ;
				endcase
				if (cnt > 90 - sent) cnt = 90 - sent;
				mode = $urandom_range(3);
				base = 8'($urandom_range(252));
				for (int i = 0; i < cnt; i++) begin
					if ($urandom_range(15) == 0) mode = $urandom_range(3);
					send_pixel(pick_pixel(mode, base));
				end
				sent += cnt;
			end
		end

		// Start of the widest row, then a tall narrow column that wraps the line store.
		set_frame(1024, 1, 7);
		for (int i = 0; i < 24; i++) send_pixel(8'($urandom_range(255)));
		set_frame(1, 4096, 7);
		for (int i = 0; i < 30; i++) send_pixel(8'($urandom_range(255)));

		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Streamed %0d pixels over %0d frame settings; %0d decisions checked.",
			sb.pixels, frames, sb.decisions);
		$display("Mismatches: %0d.", sb.mismatches);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
